### rtl/core/mlp_inference_argmax_top_defines.svh
// ---------------------------------------------------------------------------
// MLP inference assertion macros
// Concurrent assertion wrappers, clocked on i_clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef MLP_INFERENCE_ARGMAX_TOP_DEFINES_SVH
`define MLP_INFERENCE_ARGMAX_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define MLPIA_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("mlpia assertion failed");
`define MLPIA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mlpia assertion failed");
`else
`define MLPIA_ASSERT(label, prop)
`define MLPIA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/core/mlpia_pkg.sv
// ---------------------------------------------------------------------------
// MLP inference package
// Sizes, codes, command/status structs and the sigmoid lookup.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mlpia_pkg;

    localparam int WEIGHT_WORDS    = 65536;
    localparam int BIAS_WORDS      = 2048;
    localparam int MAX_LAYER_SIZE  = 1024;
    localparam int MAX_OUTPUTS     = 16;

    localparam int WADDR_W    = $clog2(WEIGHT_WORDS);
    localparam int BADDR_W    = $clog2(BIAS_WORDS);
    localparam int AADDR_W    = $clog2(MAX_LAYER_SIZE);
    localparam int OUT_IDX_W  = $clog2(MAX_OUTPUTS);
    localparam int SIZE_W     = 11;
    localparam int OUT_SIZE_W = 5;
    localparam int NL_W       = 3;
    localparam int LAYER_W    = 2;
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 16;
    localparam int OPCODE_W   = 2;
    localparam int ACT_W      = 13;
    localparam int SIG_IDX_W  = 8;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int ACC_W      = 42;
    localparam int FRAC_W     = 12;
    localparam int Z_W        = ACC_W - FRAC_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [SIZE_W-1:0]     LAYER_MAX = SIZE_W'(MAX_LAYER_SIZE);
    localparam logic [OUT_SIZE_W-1:0] OUT_MAX   = OUT_SIZE_W'(MAX_OUTPUTS);

    localparam logic [OPCODE_W-1:0] OP_WEIGHT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_BIAS   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_ACT    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_SIZE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIDDEN_ONE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIDDEN_TWO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SIZE = 3'd4;

    // 4096 / (1 + e^(j/16)), rounded, j = 0..128
    localparam logic [11:0] SIG_TAIL [0:128] = '{
        12'd2048, 12'd1984, 12'd1920, 12'd1857, 12'd1793, 12'd1731, 12'd1668, 12'd1607,
        12'd1546, 12'd1487, 12'd1428, 12'd1370, 12'd1314, 12'd1259, 12'd1205, 12'd1153,
        12'd1102, 12'd1052, 12'd1004, 12'd957,  12'd912,  12'd869,  12'd827,  12'd786,
        12'd747,  12'd710,  12'd674,  12'd639,  12'd606,  12'd575,  12'd545,  12'd516,
        12'd488,  12'd462,  12'd437,  12'd413,  12'd391,  12'd369,  12'd349,  12'd329,
        12'd311,  12'd293,  12'd277,  12'd261,  12'd246,  12'd232,  12'd219,  12'd206,
        12'd194,  12'd183,  12'd172,  12'd162,  12'd153,  12'd144,  12'd136,  12'd128,
        12'd120,  12'd113,  12'd106,  12'd100,  12'd94,   12'd89,   12'd83,   12'd78,
        12'd74,   12'd69,   12'd65,   12'd61,   12'd58,   12'd54,   12'd51,   12'd48,
        12'd45,   12'd42,   12'd40,   12'd37,   12'd35,   12'd33,   12'd31,   12'd29,
        12'd27,   12'd26,   12'd24,   12'd23,   12'd21,   12'd20,   12'd19,   12'd18,
        12'd17,   12'd16,   12'd15,   12'd14,   12'd13,   12'd12,   12'd11,   12'd11,
        12'd10,   12'd10,   12'd9,    12'd8,    12'd8,    12'd7,    12'd7,    12'd7,
        12'd6,    12'd6,    12'd5,    12'd5,    12'd5,    12'd5,    12'd4,    12'd4,
        12'd4,    12'd4,    12'd3,    12'd3,    12'd3,    12'd3,    12'd3,    12'd2,
        12'd2,    12'd2,    12'd2,    12'd2,    12'd2,    12'd2,    12'd2,    12'd1,
        12'd1
    };

    // Symmetric around the midpoint: negative side reads the mirrored tail,
    // positive side is one minus the tail read directly.
    function automatic logic [ACT_W-1:0] sig_value(input logic [SIG_IDX_W-1:0] idx);
        logic [SIG_IDX_W-1:0] j;
        logic [11:0]          f;
        if (idx[SIG_IDX_W-1]) begin
            j = {1'b0, idx[SIG_IDX_W-2:0]};
        end else begin
            j = 8'd128 - idx;
        end
        f = SIG_TAIL[j];
        if (idx[SIG_IDX_W-1]) begin
            return 13'd4096 - {1'b0, f};
        end
        return {1'b0, f};
    endfunction

    function automatic logic [SIZE_W-1:0] clamp_layer(input logic [SIZE_W-1:0] v);
        if (v == '0) begin
            return SIZE_W'(1);
        end
        if (v > LAYER_MAX) begin
            return LAYER_MAX;
        end
        return v;
    endfunction

    function automatic logic [OUT_SIZE_W-1:0] clamp_out(input logic [OUT_SIZE_W-1:0] v);
        if (v == '0) begin
            return OUT_SIZE_W'(1);
        end
        if (v > OUT_MAX) begin
            return OUT_MAX;
        end
        return v;
    endfunction

    typedef struct packed {
        logic                  load_wt;
        logic                  load_bias;
        logic                  load_act;
        logic                  issue;
        logic                  first;
        logic                  last_col;
        logic [AADDR_W-1:0]    row;
        logic [WADDR_W-1:0]    wt_addr;
        logic [AADDR_W-1:0]    act_addr;
        logic [BADDR_W-1:0]    bias_addr;
        logic                  src_pong;
        logic                  dst_pong;
        logic                  dst_final;
        logic                  load_out;
        logic [OUT_IDX_W-1:0]  emit_idx;
        logic                  emit_last;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;
        logic out_free;
    } t_dp_sts;

endpackage

### rtl/core/mlpia_ram.sv
// ---------------------------------------------------------------------------
// MLP inference RAM
// Simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlpia_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/mlpia_dp.sv
// ---------------------------------------------------------------------------
// MLP inference datapath
// Stores, MAC pipeline, rounding/saturation, sigmoid, argmax, output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlpia_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mlpia_pkg::t_dp_cmd                  i_cmd,
    output mlpia_pkg::t_dp_sts                  o_sts,
    input  logic [mlpia_pkg::ADDR_W-1:0]        i_address,
    input  logic signed [mlpia_pkg::DATA_W-1:0] i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [mlpia_pkg::OUT_IDX_W-1:0]     o_neuron_index,
    output logic [mlpia_pkg::ACT_W-1:0]         o_activation,
    output logic [mlpia_pkg::OUT_IDX_W-1:0]     o_predicted_class,
    output logic                                o_last_res
);

    localparam int DW = mlpia_pkg::DATA_W;
    localparam int AW = mlpia_pkg::AADDR_W;
    localparam int OW = mlpia_pkg::OUT_IDX_W;
    localparam int XW = mlpia_pkg::ACT_W;

    logic [DW-1:0] w_wt_q, w_bias_q, w_ping_q, w_pong_q;
    logic          w_ping_we, w_pong_we;
    logic [AW-1:0] w_ping_waddr;
    logic [DW-1:0] w_ping_wdata;
    logic [XW-1:0] w_sig;

    // stage 1: RAM read data
    logic          r_s1_vld, r_s1_first, r_s1_last, r_s1_src_pong, r_s1_dst_pong, r_s1_dst_final;
    logic [AW-1:0] r_s1_row;
    // stage 2: product
    logic                                 r_s2_vld, r_s2_first, r_s2_last;
    logic                                 r_s2_dst_pong, r_s2_dst_final;
    logic [AW-1:0]                        r_s2_row;
    logic signed [mlpia_pkg::PROD_W-1:0]  r_s2_prod;
    logic signed [DW-1:0]                 r_s2_bias;
    // stage 3: accumulator
    logic                                 r_s3_done, r_s3_dst_pong, r_s3_dst_final;
    logic [AW-1:0]                        r_s3_row;
    logic signed [mlpia_pkg::ACC_W-1:0]   r_acc;
    logic signed [DW-1:0]                 r_s3_bias;
    // stage 4: bias and rounding offset
    logic                                 r_s4_vld, r_s4_dst_pong, r_s4_dst_final;
    logic [AW-1:0]                        r_s4_row;
    logic signed [mlpia_pkg::ACC_W-1:0]   r_s4_pre;
    // stage 5: saturated table index
    logic                                 r_s5_vld, r_s5_dst_pong, r_s5_dst_final;
    logic [AW-1:0]                        r_s5_row;
    logic [mlpia_pkg::SIG_IDX_W-1:0]      r_s5_idx;

    logic signed [DW-1:0]                 w_src;
    logic signed [mlpia_pkg::PROD_W-1:0]  w_prod;
    logic signed [mlpia_pkg::ACC_W-1:0]   w_prod_ext, w_bias_ext;
    logic signed [mlpia_pkg::Z_W-1:0]     w_z;
    logic [DW-1:0]                        w_z16;
    logic                                 w_pos_ovf, w_neg_ovf;

    logic [XW-1:0] r_final [mlpia_pkg::MAX_OUTPUTS];
    logic [XW-1:0] r_best_val;
    logic [OW-1:0] r_best_idx;

    logic          r_out_valid;
    logic [OW-1:0] r_out_idx, r_out_class;
    logic [XW-1:0] r_out_act;
    logic          r_out_last;

    assign w_ping_we    = i_cmd.load_act | (r_s5_vld & ~r_s5_dst_pong & ~r_s5_dst_final);
    assign w_pong_we    = r_s5_vld & r_s5_dst_pong;
    assign w_ping_waddr = i_cmd.load_act ? i_address[AW-1:0] : r_s5_row;
    assign w_ping_wdata = i_cmd.load_act ? i_value : {{(DW-XW){1'b0}}, w_sig};

    mlpia_ram #(.WIDTH(DW), .DEPTH(mlpia_pkg::WEIGHT_WORDS)) u_wt_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_wt),
        .i_waddr (i_address[mlpia_pkg::WADDR_W-1:0]),
        .i_wdata (i_value),
        .i_raddr (i_cmd.wt_addr),
        .o_rdata (w_wt_q)
    );

    mlpia_ram #(.WIDTH(DW), .DEPTH(mlpia_pkg::BIAS_WORDS)) u_bias_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_bias),
        .i_waddr (i_address[mlpia_pkg::BADDR_W-1:0]),
        .i_wdata (i_value),
        .i_raddr (i_cmd.bias_addr),
        .o_rdata (w_bias_q)
    );

    mlpia_ram #(.WIDTH(DW), .DEPTH(mlpia_pkg::MAX_LAYER_SIZE)) u_ping_ram (
        .i_clk   (i_clk),
        .i_we    (w_ping_we),
        .i_waddr (w_ping_waddr),
        .i_wdata (w_ping_wdata),
        .i_raddr (i_cmd.act_addr),
        .o_rdata (w_ping_q)
    );

    mlpia_ram #(.WIDTH(DW), .DEPTH(mlpia_pkg::MAX_LAYER_SIZE)) u_pong_ram (
        .i_clk   (i_clk),
        .i_we    (w_pong_we),
        .i_waddr (r_s5_row),
        .i_wdata ({{(DW-XW){1'b0}}, w_sig}),
        .i_raddr (i_cmd.act_addr),
        .o_rdata (w_pong_q)
    );

    assign w_src      = r_s1_src_pong ? w_pong_q : w_ping_q;
    assign w_prod     = $signed(w_wt_q) * w_src;
    assign w_prod_ext = mlpia_pkg::ACC_W'(r_s2_prod);
    assign w_bias_ext = {{(mlpia_pkg::ACC_W-DW-mlpia_pkg::FRAC_W){r_s3_bias[DW-1]}},
                         r_s3_bias, {mlpia_pkg::FRAC_W{1'b0}}};

    // floor shift, then saturate to 16 bits
    assign w_z       = r_s4_pre[mlpia_pkg::ACC_W-1:mlpia_pkg::FRAC_W];
    assign w_pos_ovf = ~w_z[mlpia_pkg::Z_W-1] & (|w_z[mlpia_pkg::Z_W-2:DW-1]);
    assign w_neg_ovf = w_z[mlpia_pkg::Z_W-1] & ~(&w_z[mlpia_pkg::Z_W-2:DW-1]);
    assign w_z16     = w_pos_ovf ? 16'h7FFF : (w_neg_ovf ? 16'h8000 : w_z[DW-1:0]);

    assign w_sig = mlpia_pkg::sig_value(r_s5_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_done <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
        end else begin
            r_s1_vld  <= i_cmd.issue;
            r_s2_vld  <= r_s1_vld;
            r_s3_done <= r_s2_vld & r_s2_last;
            r_s4_vld  <= r_s3_done;
            r_s5_vld  <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_first     <= i_cmd.first;
        r_s1_last      <= i_cmd.last_col;
        r_s1_row       <= i_cmd.row;
        r_s1_src_pong  <= i_cmd.src_pong;
        r_s1_dst_pong  <= i_cmd.dst_pong;
        r_s1_dst_final <= i_cmd.dst_final;

        r_s2_first     <= r_s1_first;
        r_s2_last      <= r_s1_last;
        r_s2_row       <= r_s1_row;
        r_s2_dst_pong  <= r_s1_dst_pong;
        r_s2_dst_final <= r_s1_dst_final;
        r_s2_prod      <= w_prod;
        r_s2_bias      <= w_bias_q;

        if (r_s2_vld) begin
            r_acc <= r_s2_first ? w_prod_ext : r_acc + w_prod_ext;
        end
        r_s3_row       <= r_s2_row;
        r_s3_dst_pong  <= r_s2_dst_pong;
        r_s3_dst_final <= r_s2_dst_final;
        r_s3_bias      <= r_s2_bias;

        r_s4_pre       <= r_acc + w_bias_ext + mlpia_pkg::ACC_W'(2048);
        r_s4_row       <= r_s3_row;
        r_s4_dst_pong  <= r_s3_dst_pong;
        r_s4_dst_final <= r_s3_dst_final;

        r_s5_idx       <= {~w_z16[DW-1], w_z16[DW-2:DW-mlpia_pkg::SIG_IDX_W]};
        r_s5_row       <= r_s4_row;
        r_s5_dst_pong  <= r_s4_dst_pong;
        r_s5_dst_final <= r_s4_dst_final;
    end

    // final layer results and running argmax, first maximum wins
    always_ff @(posedge i_clk) begin
        if (r_s5_vld && r_s5_dst_final) begin
            r_final[r_s5_row[OW-1:0]] <= w_sig;
            if ((r_s5_row == '0) || (w_sig > r_best_val)) begin
                r_best_val <= w_sig;
                r_best_idx <= r_s5_row[OW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_idx   <= i_cmd.emit_idx;
            r_out_act   <= r_final[i_cmd.emit_idx];
            r_out_class <= i_cmd.emit_last ? r_best_idx : '0;
            r_out_last  <= i_cmd.emit_last;
        end
    end

    assign o_sts.busy     = r_s1_vld | r_s2_vld | r_s3_done | r_s4_vld | r_s5_vld;
    assign o_sts.out_free = ~r_out_valid | i_out_ready;

    assign o_out_valid       = r_out_valid;
    assign o_neuron_index    = r_out_idx;
    assign o_activation      = r_out_act;
    assign o_predicted_class = r_out_class;
    assign o_last_res        = r_out_last;

endmodule

### rtl/core/mlpia_ctrl.sv
// ---------------------------------------------------------------------------
// MLP inference controller
// Config registers, load decode, layer/row/column sequencing, result emit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mlp_inference_argmax_top_defines.svh"

module mlpia_ctrl (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [mlpia_pkg::OPCODE_W-1:0]       i_opcode,
    input  logic                                 i_last,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mlpia_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mlpia_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output mlpia_pkg::t_dp_cmd                   o_cmd,
    input  mlpia_pkg::t_dp_sts                   i_sts
);

    localparam int SW = mlpia_pkg::SIZE_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MAC   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [mlpia_pkg::NL_W-1:0]       r_layer_count;
    logic [SW-1:0]                    r_input_size, r_hidden_one, r_hidden_two;
    logic [mlpia_pkg::OUT_SIZE_W-1:0] r_output_size;

    logic [SW-1:0]                    r_col, n_col, r_row, n_row;
    logic [mlpia_pkg::WADDR_W-1:0]    r_wptr, n_wptr;
    logic [mlpia_pkg::BADDR_W-1:0]    r_bptr, n_bptr;
    logic [mlpia_pkg::LAYER_W-1:0]    r_layer, n_layer;
    logic [mlpia_pkg::OUT_IDX_W-1:0]  r_emit, n_emit;

    logic [mlpia_pkg::NL_W-1:0]       w_nl;
    logic [SW-1:0]                    w_sz0, w_sz1, w_sz2, w_cols, w_rows;
    logic [mlpia_pkg::OUT_SIZE_W-1:0] w_out_sz;
    logic                             w_last_layer, w_col_end, w_row_end, w_emit_last;
    logic                             w_in_acc;

    // config writes, indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer_count <= 3'd3;
            r_input_size  <= 11'd784;
            r_hidden_one  <= 11'd32;
            r_hidden_two  <= 11'd16;
            r_output_size <= 5'd10;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mlpia_pkg::CFG_LAYER_COUNT: r_layer_count <= i_cfg_data[mlpia_pkg::NL_W-1:0];
                mlpia_pkg::CFG_INPUT_SIZE:  r_input_size  <= i_cfg_data;
                mlpia_pkg::CFG_HIDDEN_ONE:  r_hidden_one  <= i_cfg_data;
                mlpia_pkg::CFG_HIDDEN_TWO:  r_hidden_two  <= i_cfg_data;
                mlpia_pkg::CFG_OUTPUT_SIZE:
                    r_output_size <= i_cfg_data[mlpia_pkg::OUT_SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    assign w_nl = (r_layer_count < 3'd2) ? 3'd2 :
                  ((r_layer_count > 3'd4) ? 3'd4 : r_layer_count);
    assign w_sz0    = mlpia_pkg::clamp_layer(r_input_size);
    assign w_sz1    = mlpia_pkg::clamp_layer(r_hidden_one);
    assign w_sz2    = mlpia_pkg::clamp_layer(r_hidden_two);
    assign w_out_sz = mlpia_pkg::clamp_out(r_output_size);

    assign w_last_layer = (({1'b0, r_layer} + 3'd2) == w_nl);
    assign w_cols = (r_layer == 2'd0) ? w_sz0 : ((r_layer == 2'd1) ? w_sz1 : w_sz2);
    assign w_rows = w_last_layer ? SW'(w_out_sz) : ((r_layer == 2'd0) ? w_sz1 : w_sz2);

    assign w_col_end   = (r_col == (w_cols - 11'd1));
    assign w_row_end   = (r_row == (w_rows - 11'd1));
    assign w_emit_last = (({1'b0, r_emit} + 5'd1) == w_out_sz);

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid & o_in_ready;

    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        n_row   = r_row;
        n_wptr  = r_wptr;
        n_bptr  = r_bptr;
        n_layer = r_layer;
        n_emit  = r_emit;

        o_cmd           = '0;
        o_cmd.load_wt   = w_in_acc & (i_opcode == mlpia_pkg::OP_WEIGHT);
        o_cmd.load_bias = w_in_acc & (i_opcode == mlpia_pkg::OP_BIAS);
        o_cmd.load_act  = w_in_acc & (i_opcode == mlpia_pkg::OP_ACT);
        o_cmd.first     = (r_col == '0);
        o_cmd.last_col  = w_col_end;
        o_cmd.row       = r_row[mlpia_pkg::AADDR_W-1:0];
        o_cmd.wt_addr   = r_wptr;
        o_cmd.act_addr  = r_col[mlpia_pkg::AADDR_W-1:0];
        o_cmd.bias_addr = r_bptr;
        o_cmd.src_pong  = r_layer[0];
        o_cmd.dst_final = w_last_layer;
        o_cmd.dst_pong  = ~w_last_layer & ~r_layer[0];
        o_cmd.emit_idx  = r_emit;
        o_cmd.emit_last = w_emit_last;

        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.load_act && i_last) begin
                    n_state = S_MAC;
                    n_col   = '0;
                    n_row   = '0;
                    n_wptr  = '0;
                    n_bptr  = '0;
                    n_layer = '0;
                end
            end
            S_MAC: begin
                o_cmd.issue = 1'b1;
                n_wptr      = r_wptr + 1'b1;
                if (w_col_end) begin
                    n_col  = '0;
                    n_row  = r_row + 1'b1;
                    n_bptr = r_bptr + 1'b1;
                    if (w_row_end) begin
                        n_state = S_DRAIN;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_sts.busy) begin
                    if (w_last_layer) begin
                        n_state = S_EMIT;
                        n_emit  = '0;
                    end else begin
                        n_state = S_MAC;
                        n_layer = r_layer + 1'b1;
                        n_row   = '0;
                        n_col   = '0;
                    end
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_emit         = r_emit + 1'b1;
                    if (w_emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_wptr  <= '0;
            r_bptr  <= '0;
            r_layer <= '0;
            r_emit  <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_wptr  <= n_wptr;
            r_bptr  <= n_bptr;
            r_layer <= n_layer;
            r_emit  <= n_emit;
        end
    end

    `MLPIA_ASSERT(a_drain_exit_empty, ((r_state == S_DRAIN) && (n_state != S_DRAIN)) |-> !i_sts.busy)
    `MLPIA_ASSERT(a_load_out_free, o_cmd.load_out |-> i_sts.out_free)
    `MLPIA_ASSERT_NEXT(a_mac_wptr_step, (r_state == S_MAC), (r_wptr == $past(r_wptr + 1'b1)))
    `MLPIA_ASSERT(a_emit_in_range, (r_state == S_EMIT) |-> (r_emit < w_out_sz))

endmodule

### rtl/core/mlp_inference_argmax_top.sv
// ---------------------------------------------------------------------------
// MLP inference with argmax
// Sigmoid multilayer perceptron (1 to 3 weight layers) with argmax output.
// ---------------------------------------------------------------------------
// Load requests (weight, bias, input activation) are taken one per cycle and
// written straight into on-chip RAM. An input activation request with last
// set starts inference; the input channel then stays not ready until the
// final result has been placed in the output register. Inference runs on a
// single multiply-accumulate pipeline fed by one weight RAM read per cycle,
// and each layer drains the pipeline before the next starts; results are
// emitted one per cycle while the consumer keeps ready high. Weights are read
// from one flat address that simply counts up through all layers, biases
// likewise. Hidden layers ping-pong between two activation RAMs, so a
// four-layer network overwrites the start of the input activations. Each
// output neuron gives one result; the result with last_res set carries the
// first index of the largest activation. Configuration writes are always
// ready and must only be issued while no inference is in flight.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlp_inference_argmax_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // load / start requests
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [mlpia_pkg::OPCODE_W-1:0]      i_opcode,
    input  logic [mlpia_pkg::ADDR_W-1:0]        i_address,
    input  logic signed [mlpia_pkg::DATA_W-1:0] i_value,
    input  logic                                i_last,
    // results
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [mlpia_pkg::OUT_IDX_W-1:0]     o_neuron_index,
    output logic [mlpia_pkg::ACT_W-1:0]         o_activation,
    output logic [mlpia_pkg::OUT_IDX_W-1:0]     o_predicted_class,
    output logic                                o_last_res,
    // configuration
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mlpia_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mlpia_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // controller drives all sequencing; datapath holds RAMs and arithmetic
    mlpia_pkg::t_dp_cmd w_cmd;
    mlpia_pkg::t_dp_sts w_sts;

    mlpia_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_last      (i_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    mlpia_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_address         (i_address),
        .i_value           (i_value),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_neuron_index    (o_neuron_index),
        .o_activation      (o_activation),
        .o_predicted_class (o_predicted_class),
        .o_last_res        (o_last_res)
    );

endmodule
